// File: hw/rtl/ots_pkg.sv
// Shared types and constants for the odometer / tachometer / speed counter.
// No dependencies; used by every RTL file of the block by scoped names.
`default_nettype none

package ots_pkg;

	// default parameter values
	localparam int ODO_DIGITS_DEF  = 6;
	localparam int COUNT_WIDTH_DEF = 14;

	// fixed field and register widths
	localparam int ODO_W         = 24;
	localparam int RPM_W         = 22;
	localparam int SPEED_W       = 21;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 2;
	localparam int PPU_W         = 16;
	localparam int WIN_W         = 16;
	localparam int RPM_SCALE_W   = 8;
	localparam int SPEED_SCALE_W = 16;

	// register values after reset
	localparam logic [PPU_W-1:0]         PPU_RESET         = 16'd893;
	localparam logic [WIN_W-1:0]         WINDOW_RESET      = 16'd1000;
	localparam logic [RPM_SCALE_W-1:0]   RPM_SCALE_RESET   = 8'd60;
	localparam logic [SPEED_SCALE_W-1:0] SPEED_SCALE_RESET = 16'd4032;

	// decimal digit limit and speed divisor (scale is in thousandths)
	localparam logic [3:0] BCD_MAX   = 4'd9;
	localparam int         SPEED_DIV = 1000;

	// register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PULSES_PER_UNIT   = 2'd0,
		REG_WINDOW_TICKS      = 2'd1,
		REG_RPM_SCALE         = 2'd2,
		REG_SPEED_SCALE_MILLI = 2'd3
	} cfg_reg_t;

	// input word
	typedef struct packed {
		logic wheel_pulse;
		logic engine_pulse;
		logic tick;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [ODO_W-1:0]   odometer_bcd;
		logic [RPM_W-1:0]   engine_rpm;
		logic [SPEED_W-1:0] road_speed;
		logic               window_done;
	} out_word_t;

	// load enables of the scale pipeline stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

// File: hw/rtl/ots_digit_cell.sv
// One decimal odometer digit: holds its BCD value and passes a carry upward.
// Depends on ots_pkg for the digit limit.
`default_nettype none

module ots_digit_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       carry_in,
	output logic            carry_out,
	output logic [3:0]      digit_next
);

	logic [3:0] digit_q;

	// advance on carry, wrap nine to zero and pass the carry on
	always_comb begin
		carry_out  = carry_in && (digit_q >= ots_pkg::BCD_MAX);
		digit_next = digit_q;
		if (carry_in) begin
			digit_next = (digit_q >= ots_pkg::BCD_MAX) ? 4'd0 : digit_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (en) begin
			digit_q <= digit_next;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ots_scaler.sv
// Scale pipeline: rpm and speed products, divide by a thousand through a
// reciprocal split in two partial products, and the held window results.
// Depends on ots_pkg.
`default_nettype none

module ots_scaler #(
	parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ots_pkg::stage_en_t                 en,
	input  wire logic                               done_s1,
	input  wire logic [COUNT_WIDTH-1:0]             eng_s1,
	input  wire logic [COUNT_WIDTH-1:0]             whl_s1,
	input  wire logic [ots_pkg::RPM_SCALE_W-1:0]    rpm_scale,
	input  wire logic [ots_pkg::SPEED_SCALE_W-1:0]  speed_scale,
	output logic                                    done_s4,
	output logic [ots_pkg::RPM_W-1:0]               rpm_s4,
	output logic [ots_pkg::SPEED_W-1:0]             speed_s4
);

	localparam int RPW  = COUNT_WIDTH + ots_pkg::RPM_SCALE_W;
	localparam int PW   = COUNT_WIDTH + ots_pkg::SPEED_SCALE_W;
	localparam int SH   = PW + $clog2(ots_pkg::SPEED_DIV);
	localparam int MW   = PW + 1;
	localparam int H    = (MW + 1) / 2;
	localparam int MH   = MW - H;
	localparam int SUMW = PW + MW + 1;
	localparam int QW   = PW - 9;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(ots_pkg::SPEED_DIV) - 64'd1) / 64'(ots_pkg::SPEED_DIV);
	localparam logic [H-1:0]  M_LO = RECIP[H-1:0];
	localparam logic [MH-1:0] M_HI = RECIP[MW-1:H];

	logic [RPW-1:0]                rpm_prod_s2;
	logic [PW-1:0]                 sp_prod_s2;
	logic                          done_s2;
	logic [PW+H-1:0]               pp_lo_s3;
	logic [PW+MH-1:0]              pp_hi_s3;
	logic [ots_pkg::RPM_W-1:0]     rpm_s3;
	logic                          done_s3;
	logic [RPW+ots_pkg::RPM_W-1:0] rpm_ext;
	logic [SUMW-1:0]               quot_sum;
	logic [QW-1:0]                 quot;
	logic [QW+ots_pkg::SPEED_W-1:0] quot_ext;

	// widen or cut the rpm product to the result field
	assign rpm_ext = {{ots_pkg::RPM_W{1'b0}}, rpm_prod_s2};

	// recombine partial products and take the quotient bits
	assign quot_sum = SUMW'(pp_lo_s3) + (SUMW'(pp_hi_s3) << H);
	assign quot     = quot_sum[SH +: QW];
	assign quot_ext = {{ots_pkg::SPEED_W{1'b0}}, quot};

	// stage 2: window count products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			rpm_prod_s2 <= RPW'(eng_s1) * RPW'(rpm_scale);
			sp_prod_s2  <= PW'(whl_s1) * PW'(speed_scale);
			done_s2     <= done_s1;
		end
	end

	// stage 3: reciprocal partial products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pp_lo_s3 <= (PW+H)'(sp_prod_s2) * (PW+H)'(M_LO);
			pp_hi_s3 <= (PW+MH)'(sp_prod_s2) * (PW+MH)'(M_HI);
			rpm_s3   <= rpm_ext[ots_pkg::RPM_W-1:0];
			done_s3  <= done_s2;
		end
	end

	// stage 4: update the held results only on a closing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4  <= 1'b0;
			rpm_s4   <= '0;
			speed_s4 <= '0;
		end else if (en.s4) begin
			done_s4 <= done_s3;
			if (done_s3) begin
				rpm_s4   <= rpm_s3;
				speed_s4 <= quot_ext[ots_pkg::SPEED_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/odometer_tachometer_speed_counter.sv
// Top level: configuration registers, distance prescaler, digit cell row,
// gate window counters and the handshake around the scale pipeline.
// Depends on ots_pkg, ots_digit_cell and ots_scaler.
//
//   channel   direction  signals                      word
//   input     in         in_valid / in_ready          ots_pkg::in_word_t
//   result    out        out_valid / out_ready        ots_pkg::out_word_t
//   config    in         cfg_we, cfg_index, cfg_data  write only, no wait
//
// One word per cycle sustained while out_ready stays high; a result word is
// valid once its word has passed the four register stages s1 to s4 of the
// pipeline, and it leaves when out_ready is high.
// Counters, prescaler and odometer cells update at acceptance; the later
// stages carry the window counts through the multipliers and the odometer value beside them.
// Reset loads the register defaults and the gate timer and clears all other counts; no clearing pass.
// A stalled result holds stage 4; ready ripples back through empty stages.
`default_nettype none

module odometer_tachometer_speed_counter #(
	parameter int ODO_DIGITS  = ots_pkg::ODO_DIGITS_DEF,
	parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire ots_pkg::in_word_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output ots_pkg::out_word_t                    out_data,
	input  wire logic                             cfg_we,
	input  wire logic [ots_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ots_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PACK_DIGITS =
		(ODO_DIGITS < ots_pkg::ODO_W / 4) ? ODO_DIGITS : ots_pkg::ODO_W / 4;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// configuration registers
	logic [ots_pkg::PPU_W-1:0]         ppu_q;
	logic [ots_pkg::WIN_W-1:0]         window_q;
	logic [ots_pkg::RPM_SCALE_W-1:0]   rpm_scale_q;
	logic [ots_pkg::SPEED_SCALE_W-1:0] speed_scale_q;

	// counting state
	logic [ots_pkg::PPU_W-1:0] dist_q;
	logic [COUNT_WIDTH-1:0]    wheel_cnt_q;
	logic [COUNT_WIDTH-1:0]    eng_cnt_q;
	logic [ots_pkg::WIN_W-1:0] ticks_left_q;

	// pipeline
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      rdy1, rdy2, rdy3, rdy4;
	logic                      done_s1;
	logic [COUNT_WIDTH-1:0]    eng_s1, whl_s1;
	logic [ots_pkg::ODO_W-1:0] odo_s1, odo_s2, odo_s3, odo_s4;
	logic                      done_s4;
	logic [ots_pkg::RPM_W-1:0]   rpm_s4;
	logic [ots_pkg::SPEED_W-1:0] speed_s4;
	ots_pkg::stage_en_t        stage_en;

	// combinational next state
	logic                      accept;
	logic [ots_pkg::PPU_W:0]   prescale_inc;
	logic                      unit_step;
	logic [ots_pkg::PPU_W-1:0] dist_next;
	logic [COUNT_WIDTH-1:0]    wheel_upd, eng_upd;
	logic                      close;
	logic [ots_pkg::WIN_W-1:0] ticks_next;
	logic [ots_pkg::ODO_W-1:0] odo_next;
	logic [ODO_DIGITS-1:0]     carry;
	logic [3:0]                digit_next [ODO_DIGITS];
	logic                      odo_wrap;

	// handshake: each stage takes a word when empty or when the next one moves
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign accept   = in_valid && in_ready;

	assign stage_en.s2 = rdy2 && v_s1;
	assign stage_en.s3 = rdy3 && v_s2;
	assign stage_en.s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q         <= ots_pkg::PPU_RESET;
			window_q      <= ots_pkg::WINDOW_RESET;
			rpm_scale_q   <= ots_pkg::RPM_SCALE_RESET;
			speed_scale_q <= ots_pkg::SPEED_SCALE_RESET;
		end else if (cfg_we) begin
			unique case (ots_pkg::cfg_reg_t'(cfg_index))
				ots_pkg::REG_PULSES_PER_UNIT:   ppu_q         <= cfg_data;
				ots_pkg::REG_WINDOW_TICKS:      window_q      <= cfg_data;
				ots_pkg::REG_RPM_SCALE:         rpm_scale_q   <= cfg_data[ots_pkg::RPM_SCALE_W-1:0];
				ots_pkg::REG_SPEED_SCALE_MILLI: speed_scale_q <= cfg_data;
			endcase
		end
	end

	// prescaler, saturating window counts and gate timer
	always_comb begin
		prescale_inc = {1'b0, dist_q} + 17'd1;
		unit_step    = in_data.wheel_pulse && (prescale_inc >= {1'b0, ppu_q});
		dist_next    = dist_q;
		if (in_data.wheel_pulse) begin
			dist_next = unit_step ? '0 : prescale_inc[ots_pkg::PPU_W-1:0];
		end
		wheel_upd = wheel_cnt_q;
		if (in_data.wheel_pulse && (wheel_cnt_q != CNT_MAX)) begin
			wheel_upd = wheel_cnt_q + COUNT_WIDTH'(1);
		end
		eng_upd = eng_cnt_q;
		if (in_data.engine_pulse && (eng_cnt_q != CNT_MAX)) begin
			eng_upd = eng_cnt_q + COUNT_WIDTH'(1);
		end
		close      = in_data.tick && (ticks_left_q <= 16'd1);
		ticks_next = ticks_left_q;
		if (close) begin
			ticks_next = window_q;
		end else if (in_data.tick) begin
			ticks_next = ticks_left_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q       <= '0;
			wheel_cnt_q  <= '0;
			eng_cnt_q    <= '0;
			ticks_left_q <= ots_pkg::WINDOW_RESET;
		end else if (accept) begin
			dist_q       <= dist_next;
			wheel_cnt_q  <= close ? '0 : wheel_upd;
			eng_cnt_q    <= close ? '0 : eng_upd;
			ticks_left_q <= ticks_next;
		end
	end

	// odometer: row of digit cells, carry handed upward
	assign carry[0] = unit_step;

	for (genvar d = 0; d < ODO_DIGITS; d++) begin : g_digit
		if (d < ODO_DIGITS - 1) begin : g_mid
			ots_digit_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (accept),
				.carry_in   (carry[d]),
				.carry_out  (carry[d+1]),
				.digit_next (digit_next[d])
			);
		end else begin : g_top
			ots_digit_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (accept),
				.carry_in   (carry[d]),
				.carry_out  (odo_wrap),
				.digit_next (digit_next[d])
			);
		end
	end

	// pack the low digits into the result field
	always_comb begin
		odo_next = '0;
		for (int d = 0; d < PACK_DIGITS; d++) begin
			odo_next[4*d +: 4] = digit_next[d];
		end
	end

	// stage 1: capture counts, closing flag and odometer value of each accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1 <= close;
			eng_s1  <= eng_upd;
			whl_s1  <= wheel_upd;
			odo_s1  <= odo_next;
		end
	end

	// carry the odometer value beside the scale pipeline
	always_ff @(posedge clk) begin
		if (stage_en.s2) odo_s2 <= odo_s1;
		if (stage_en.s3) odo_s3 <= odo_s2;
		if (stage_en.s4) odo_s4 <= odo_s3;
	end

	ots_scaler #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_scaler (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (stage_en),
		.done_s1     (done_s1),
		.eng_s1      (eng_s1),
		.whl_s1      (whl_s1),
		.rpm_scale   (rpm_scale_q),
		.speed_scale (speed_scale_q),
		.done_s4     (done_s4),
		.rpm_s4      (rpm_s4),
		.speed_s4    (speed_s4)
	);

	// result word
	assign out_valid             = v_s4;
	assign out_data.odometer_bcd = odo_s4;
	assign out_data.engine_rpm   = rpm_s4;
	assign out_data.road_speed   = speed_s4;
	assign out_data.window_done  = done_s4;

	// a closing tick marks the captured word as done
	a_close_marks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.tick && (ticks_left_q <= 16'd1) |=> v_s1 && done_s1)
		else $error("closing tick did not mark the word as done");

	// window counts restart after a close
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && close |=> (wheel_cnt_q == '0) && (eng_cnt_q == '0))
		else $error("window counts not cleared on close");

	// odometer wrap leaves all digits at zero
	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && odo_wrap |=> odo_s1 == '0)
		else $error("odometer wrap left nonzero digits");

	// prescaler stays below the unit length after a wheel pulse
	a_prescale_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.wheel_pulse && !cfg_we |=> (dist_q < ppu_q) || (dist_q == '0))
		else $error("prescaler out of range");

	// an empty pipeline always takes a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 && !v_s2 && !v_s3 && !v_s4 |-> in_ready)
		else $error("empty pipeline refused a word");

endmodule

`default_nettype wire
